[design/timed_unique_id_collector_unit_assert.svh]
// assertion macros for the timed unique id collector
`ifndef TIMED_UNIQUE_ID_COLLECTOR_UNIT_ASSERT_SVH
`define TIMED_UNIQUE_ID_COLLECTOR_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define TUICU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define TUICU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tuicu_pkg.sv]
// shared types and codes of the timed unique id collector
package tuicu_pkg;

    // number of entries in the id table
    localparam int TABLE_SIZE = 8;

    // operation codes of an input transfer
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUEST = 1'd1;

    // result status codes
    typedef enum logic [2:0] {
        RES_STARTED      = 3'd0,
        RES_STORED       = 3'd1,
        RES_DUPLICATE    = 3'd2,
        RES_FULL_DROPPED = 3'd3,
        RES_IGNORED      = 3'd4,
        RES_RUNNING      = 3'd5,
        RES_FINISHED     = 3'd6
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_STORE,
        S_EMIT_RD,
        S_EMIT_PUSH,
        S_EMPTY
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    capture;
        logic    start;
        logic    finish;
        logic    scan_init;
        logic    scan_step;
        logic    store;
        logic    emit_read;
        logic    emit_next;
        logic    push;
        logic    push_entry;
        status_t push_status;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       active;
        logic       close;
        logic       count_zero;
        logic       scan_done;
        logic       hit;
        logic       room;
        logic       slot_free;
        logic       emit_last;
    } sts_t;

endpackage

[design/timed_unique_id_collector_unit.sv]
// top level of the timed unique id collector
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_stall     operation, now_ms, reported_id
//   out       output     out_valid / out_stall   status, running, count, entry_index,
//                                                entry_id, entry_valid, last
//   cfg       input      cfg_write_en            cfg_index, cfg_data
//
// start, ignored item and unfinished tick: the transfer is captured in idle and the result is pushed from dispatch
// report: dispatch, then the search, then the store decision; the search reads an entry a cycle
// finishing tick: dispatch, then a table read and a result push per stored entry, or one empty result if none
// reset clears the window state and the result valid flag; the table needs no clearing
// a stalled result holds the block in any state that pushes a result, a new input waits in idle
`include "timed_unique_id_collector_unit_assert.svh"

module timed_unique_id_collector_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [tuicu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      operation,
    input  logic [31:0]                     now_ms,
    input  logic [31:0]                     reported_id,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status,
    output logic                            running,
    output logic [3:0]                      count,
    output logic [2:0]                      entry_index,
    output logic [31:0]                     entry_id,
    output logic                            entry_valid,
    output logic                            last
);

    tuicu_pkg::cmd_t cmd;
    tuicu_pkg::sts_t sts;

    // sequencing
    tuicu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // window state, table and result register
    tuicu_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .now_ms       (now_ms),
        .reported_id  (reported_id),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .status       (status),
        .running      (running),
        .count        (count),
        .entry_index  (entry_index),
        .entry_id     (entry_id),
        .entry_valid  (entry_valid),
        .last         (last),
        .cmd          (cmd),
        .sts          (sts)
    );

    // checks
    `TUICU_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall, "input taken while an item is in flight")
    `TUICU_ASSERT_NOW(a_store_needs_room, clk, rst_n, cmd.store, sts.room && !sts.hit, "id stored without room or as duplicate")
    `TUICU_ASSERT_NOW(a_not_last_is_entry, clk, rst_n, out_valid && !last, entry_valid && status == tuicu_pkg::RES_FINISHED, "non-final result is not a list entry")
    `TUICU_ASSERT_NOW(a_stored_while_running, clk, rst_n, out_valid && status == tuicu_pkg::RES_STORED, running, "id stored outside an open window")

endmodule

[design/tuicu_ram.sv]
// generic single write, single read ram with registered read data
module tuicu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/tuicu_ctrl.sv]
// controller state machine of the timed unique id collector
module tuicu_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  tuicu_pkg::sts_t sts,
    output tuicu_pkg::cmd_t cmd
);

    tuicu_pkg::state_t state_reg;
    tuicu_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tuicu_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tuicu_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tuicu_pkg::S_DISPATCH;
                end
            end
            tuicu_pkg::S_DISPATCH:
            begin
                case (sts.op)
                    tuicu_pkg::OP_TICK:
                    begin
                        if (!sts.active || !sts.close)
                        begin
                            if (sts.slot_free)
                            begin
                                state_next = tuicu_pkg::S_IDLE;
                            end
                        end
                        else if (sts.count_zero)
                        begin
                            state_next = tuicu_pkg::S_EMPTY;
                        end
                        else
                        begin
                            state_next = tuicu_pkg::S_EMIT_RD;
                        end
                    end
                    tuicu_pkg::OP_REPORT:
                    begin
                        if (!sts.active)
                        begin
                            if (sts.slot_free)
                            begin
                                state_next = tuicu_pkg::S_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = tuicu_pkg::S_SCAN;
                        end
                    end
                    default:
                    begin
                        if (sts.slot_free)
                        begin
                            state_next = tuicu_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            tuicu_pkg::S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = tuicu_pkg::S_STORE;
                end
            end
            tuicu_pkg::S_STORE:
            begin
                if (sts.slot_free)
                begin
                    state_next = tuicu_pkg::S_IDLE;
                end
            end
            tuicu_pkg::S_EMIT_RD:
            begin
                state_next = tuicu_pkg::S_EMIT_PUSH;
            end
            tuicu_pkg::S_EMIT_PUSH:
            begin
                if (sts.slot_free)
                begin
                    state_next = sts.emit_last ? tuicu_pkg::S_IDLE : tuicu_pkg::S_EMIT_RD;
                end
            end
            tuicu_pkg::S_EMPTY:
            begin
                if (sts.slot_free)
                begin
                    state_next = tuicu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tuicu_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        cmd.push_status = tuicu_pkg::RES_IGNORED;
        in_stall = (state_reg != tuicu_pkg::S_IDLE);
        case (state_reg)
            tuicu_pkg::S_IDLE:
            begin
                cmd.capture = in_valid;
            end
            tuicu_pkg::S_DISPATCH:
            begin
                case (sts.op)
                    tuicu_pkg::OP_START:
                    begin
                        if (sts.slot_free)
                        begin
                            cmd.start       = 1'b1;
                            cmd.push        = 1'b1;
                            cmd.push_status = tuicu_pkg::RES_STARTED;
                        end
                    end
                    tuicu_pkg::OP_TICK:
                    begin
                        if (!sts.active)
                        begin
                            cmd.push = sts.slot_free;
                        end
                        else if (!sts.close)
                        begin
                            cmd.push        = sts.slot_free;
                            cmd.push_status = tuicu_pkg::RES_RUNNING;
                        end
                        else
                        begin
                            cmd.finish    = 1'b1;
                            cmd.scan_init = 1'b1;
                        end
                    end
                    tuicu_pkg::OP_REPORT:
                    begin
                        if (!sts.active)
                        begin
                            cmd.push = sts.slot_free;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.push = sts.slot_free;
                    end
                endcase
            end
            tuicu_pkg::S_SCAN:
            begin
                cmd.scan_step = !sts.scan_done;
            end
            tuicu_pkg::S_STORE:
            begin
                if (sts.slot_free)
                begin
                    cmd.push = 1'b1;
                    if (sts.hit)
                    begin
                        cmd.push_status = tuicu_pkg::RES_DUPLICATE;
                    end
                    else if (sts.room)
                    begin
                        cmd.store       = 1'b1;
                        cmd.push_status = tuicu_pkg::RES_STORED;
                    end
                    else
                    begin
                        cmd.push_status = tuicu_pkg::RES_FULL_DROPPED;
                    end
                end
            end
            tuicu_pkg::S_EMIT_RD:
            begin
                cmd.emit_read = 1'b1;
            end
            tuicu_pkg::S_EMIT_PUSH:
            begin
                if (sts.slot_free)
                begin
                    cmd.push        = 1'b1;
                    cmd.push_entry  = 1'b1;
                    cmd.emit_next   = 1'b1;
                    cmd.push_status = tuicu_pkg::RES_FINISHED;
                end
            end
            tuicu_pkg::S_EMPTY:
            begin
                if (sts.slot_free)
                begin
                    cmd.push        = 1'b1;
                    cmd.push_status = tuicu_pkg::RES_FINISHED;
                end
            end
            default:
            begin
                cmd.capture = 1'b0;
            end
        endcase
    end

endmodule

[design/tuicu_dp.sv]
// datapath of the timed unique id collector: window state, id table, result register
module tuicu_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [tuicu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic [1:0]                     operation,
    input  logic [31:0]                    now_ms,
    input  logic [31:0]                    reported_id,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic [2:0]                     status,
    output logic                           running,
    output logic [3:0]                     count,
    output logic [2:0]                     entry_index,
    output logic [31:0]                    entry_id,
    output logic                           entry_valid,
    output logic                           last,
    input  tuicu_pkg::cmd_t                cmd,
    output tuicu_pkg::sts_t                sts
);

    localparam int CNT_W = $clog2(tuicu_pkg::TABLE_SIZE + 1);
    localparam int IDX_W = (tuicu_pkg::TABLE_SIZE > 1) ? $clog2(tuicu_pkg::TABLE_SIZE) : 1;

    // configuration registers
    logic [31:0]      window_ms_reg;
    logic [7:0]       max_request_reg;

    // captured input transfer
    logic [1:0]       op_reg;
    logic [31:0]      now_reg;
    logic [31:0]      aid_reg;

    // window state
    logic [CNT_W-1:0] count_reg, count_next;
    logic             active_reg, active_next;
    logic [31:0]      deadline_reg, deadline_next;
    logic [CNT_W-1:0] limit_reg, limit_next;

    // walk over the table
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             pend_reg, pend_next;
    logic             hit_reg, hit_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_status_reg, out_status_next;
    logic             out_running_reg, out_running_next;
    logic [3:0]       out_count_reg, out_count_next;
    logic [2:0]       out_index_reg, out_index_next;
    logic [31:0]      out_id_reg, out_id_next;
    logic             out_entry_valid_reg, out_entry_valid_next;
    logic             out_last_reg, out_last_next;

    logic [CNT_W-1:0] limit_sel;
    logic [31:0]      late_by;
    logic             scan_valid;
    logic             room;
    logic             emit_last;
    logic             slot_free;
    logic             rd_en;
    logic [31:0]      rd_data;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg   <= '0;
            max_request_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                tuicu_pkg::REG_WINDOW_MS:   window_ms_reg   <= cfg_data;
                tuicu_pkg::REG_MAX_REQUEST: max_request_reg <= cfg_data[7:0];
                default:                    window_ms_reg   <= window_ms_reg;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            now_reg <= now_ms;
            aid_reg <= reported_id;
        end
    end

    // id table
    tuicu_ram #(
        .WIDTH (32),
        .DEPTH (tuicu_pkg::TABLE_SIZE)
    ) u_table (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (aid_reg),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // limit from request: zero or oversize means the whole table
    assign limit_sel = (max_request_reg == 8'd0 || max_request_reg > 8'(tuicu_pkg::TABLE_SIZE))
                     ? CNT_W'(tuicu_pkg::TABLE_SIZE) : CNT_W'(max_request_reg);

    // wrap-safe deadline check and table room
    assign late_by    = now_reg - deadline_reg;
    assign room       = (count_reg < limit_reg);
    assign scan_valid = (scan_idx_reg < count_reg);
    assign emit_last  = ((scan_idx_reg + CNT_W'(1)) == count_reg);
    assign slot_free  = !out_valid_reg || !out_stall;
    assign rd_en      = (cmd.scan_step && scan_valid) || cmd.emit_read;

    // window state update
    always_comb
    begin
        count_next    = count_reg;
        active_next   = active_reg;
        deadline_next = deadline_reg;
        limit_next    = limit_reg;
        if (cmd.start)
        begin
            count_next    = '0;
            active_next   = 1'b1;
            deadline_next = now_reg + window_ms_reg;
            limit_next    = limit_sel;
        end
        else if (cmd.store)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.finish)
        begin
            active_next = 1'b0;
        end
    end

    // table walk for duplicate search and emission
    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        pend_next     = cmd.scan_step && scan_valid;
        hit_next      = hit_reg;
        if (cmd.scan_init)
        begin
            scan_idx_next = '0;
            hit_next      = 1'b0;
        end
        else
        begin
            if ((cmd.scan_step && scan_valid) || cmd.emit_next)
            begin
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end
            if (pend_reg && rd_data == aid_reg)
            begin
                hit_next = 1'b1;
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next       = out_valid_reg;
        out_status_next      = out_status_reg;
        out_running_next     = out_running_reg;
        out_count_next       = out_count_reg;
        out_index_next       = out_index_reg;
        out_id_next          = out_id_reg;
        out_entry_valid_next = out_entry_valid_reg;
        out_last_next        = out_last_reg;
        if (cmd.push)
        begin
            out_valid_next   = 1'b1;
            out_status_next  = cmd.push_status;
            out_running_next = active_next;
            out_count_next   = 4'(count_next);
            if (cmd.push_entry)
            begin
                out_index_next       = 3'(scan_idx_reg);
                out_id_next          = rd_data;
                out_entry_valid_next = 1'b1;
                out_last_next        = emit_last;
            end
            else
            begin
                out_index_next       = '0;
                out_id_next          = '0;
                out_entry_valid_next = 1'b0;
                out_last_next        = 1'b1;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            active_reg    <= 1'b0;
            deadline_reg  <= '0;
            limit_reg     <= CNT_W'(tuicu_pkg::TABLE_SIZE);
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            active_reg    <= active_next;
            deadline_reg  <= deadline_next;
            limit_reg     <= limit_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_status_reg      <= out_status_next;
        out_running_reg     <= out_running_next;
        out_count_reg       <= out_count_next;
        out_index_reg       <= out_index_next;
        out_id_reg          <= out_id_next;
        out_entry_valid_reg <= out_entry_valid_next;
        out_last_reg        <= out_last_next;
    end

    // status to controller
    always_comb
    begin
        sts.op         = op_reg;
        sts.active     = active_reg;
        sts.close      = !late_by[31] || !room;
        sts.count_zero = (count_reg == '0);
        sts.scan_done  = !scan_valid && !pend_reg;
        sts.hit        = hit_reg;
        sts.room       = room;
        sts.slot_free  = slot_free;
        sts.emit_last  = emit_last;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign running     = out_running_reg;
    assign count       = out_count_reg;
    assign entry_index = out_index_reg;
    assign entry_id    = out_id_reg;
    assign entry_valid = out_entry_valid_reg;
    assign last        = out_last_reg;

endmodule
